### design/fpli_pkg.sv
package fpli_pkg;

    localparam int DATA_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF  = 14;

    // layout of the sideband word that rides along the divider
    localparam int FLD_XQ      = 0;
    localparam int FLD_Y2      = 1;
    localparam int FLD_Y1      = 2;
    localparam int FLD_X1      = 3;
    localparam int SIDE_FIELDS = 4;

    localparam int FLAG_QNEG   = 0;
    localparam int FLAG_ZERO   = 1;
    localparam int FLAG_ACTION = 2;
    localparam int SIDE_FLAGS  = 3;

endpackage

### design/fpli_prep.sv
module fpli_prep #(
    parameter int DW = fpli_pkg::DATA_WIDTH_DEF,
    parameter int F  = fpli_pkg::FRAC_BITS_DEF
) (
    input  logic                                                 clk,
    input  logic                                                 rst_n,
    input  logic                                                 en,
    input  logic                                                 request_valid,
    input  logic                                                 action,
    input  logic signed [DW-1:0]                                 first_x,
    input  logic signed [DW-1:0]                                 second_x,
    input  logic signed [DW-1:0]                                 first_y,
    input  logic signed [DW-1:0]                                 second_y,
    input  logic signed [DW-1:0]                                 query_x,
    output logic                                                 vld,
    output logic [DW-1:0]                                        rem,
    output logic [DW+F-1:0]                                      num,
    output logic [DW-1:0]                                        den,
    output logic [fpli_pkg::SIDE_FIELDS*DW+fpli_pkg::SIDE_FLAGS-1:0] side
);
    import fpli_pkg::*;

    localparam int Q      = DW + F;
    localparam int SIDE_W = SIDE_FIELDS * DW + SIDE_FLAGS;

    logic [DW:0]       dy;
    logic [DW:0]       dx;
    logic [DW:0]       dy_mag;
    logic [DW:0]       dx_mag;
    logic [Q-1:0]      num_next;
    logic [DW-1:0]     den_next;
    logic [SIDE_W-1:0] side_next;
    logic              vld_reg;
    logic [Q-1:0]      num_reg;
    logic [DW-1:0]     den_reg;
    logic [SIDE_W-1:0] side_reg;

    assign dy     = {first_y[DW-1], first_y} - {second_y[DW-1], second_y};
    assign dx     = {first_x[DW-1], first_x} - {second_x[DW-1], second_x};
    assign dy_mag = dy[DW] ? (~dy + 1'b1) : dy;
    assign dx_mag = dx[DW] ? (~dx + 1'b1) : dx;

    assign num_next = {dy_mag[DW-1:0], {F{1'b0}}};
    assign den_next = dx_mag[DW-1:0];

    always_comb
    begin
        side_next                          = '0;
        side_next[FLD_XQ*DW +: DW]         = query_x;
        side_next[FLD_Y2*DW +: DW]         = second_y;
        side_next[FLD_Y1*DW +: DW]         = first_y;
        side_next[FLD_X1*DW +: DW]         = first_x;
        side_next[SIDE_FIELDS*DW+FLAG_QNEG]   = dy[DW] ^ dx[DW];
        side_next[SIDE_FIELDS*DW+FLAG_ZERO]   = (first_x == second_x);
        side_next[SIDE_FIELDS*DW+FLAG_ACTION] = action;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= request_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg  <= num_next;
            den_reg  <= den_next;
            side_reg <= side_next;
        end
    end

    assign vld  = vld_reg;
    assign rem  = '0;
    assign num  = num_reg;
    assign den  = den_reg;
    assign side = side_reg;

endmodule

### design/fpli_div_stage.sv
module fpli_div_stage #(
    parameter int DW     = 16,
    parameter int Q      = 30,
    parameter int SIDE_W = 67
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              vld_in,
    input  logic [DW-1:0]     rem_in,
    input  logic [Q-1:0]      num_in,
    input  logic [DW-1:0]     den_in,
    input  logic [SIDE_W-1:0] side_in,
    output logic              vld_out,
    output logic [DW-1:0]     rem_out,
    output logic [Q-1:0]      num_out,
    output logic [DW-1:0]     den_out,
    output logic [SIDE_W-1:0] side_out
);

    logic [DW:0]       trial;
    logic [DW:0]       diff;
    logic              fits;
    logic [DW-1:0]     rem_next;
    logic [Q-1:0]      num_next;
    logic              vld_reg;
    logic [DW-1:0]     rem_reg;
    logic [Q-1:0]      num_reg;
    logic [DW-1:0]     den_reg;
    logic [SIDE_W-1:0] side_reg;

    // one restoring step: quotient bit shifts in where the dividend bit left
    assign trial    = {rem_in, num_in[Q-1]};
    assign diff     = trial - {1'b0, den_in};
    assign fits     = (trial >= {1'b0, den_in});
    assign rem_next = fits ? diff[DW-1:0] : trial[DW-1:0];
    assign num_next = {num_in[Q-2:0], fits};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= vld_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            num_reg  <= num_next;
            den_reg  <= den_in;
            side_reg <= side_in;
        end
    end

    assign vld_out  = vld_reg;
    assign rem_out  = rem_reg;
    assign num_out  = num_reg;
    assign den_out  = den_reg;
    assign side_out = side_reg;

endmodule

### design/fpli_eval.sv
module fpli_eval #(
    parameter int DW = 16,
    parameter int F  = 14
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 vld_in,
    input  logic [DW+F-1:0]      quo,
    input  logic                 qneg,
    input  logic                 action,
    input  logic                 zero,
    input  logic signed [DW-1:0] first_x,
    input  logic signed [DW-1:0] first_y,
    input  logic signed [DW-1:0] second_y,
    input  logic signed [DW-1:0] query_x,
    output logic                 vld_out,
    output logic [DW-1:0]        res_y,
    output logic                 res_zero,
    output logic                 res_sat
);

    localparam int Q   = DW + F;
    localparam int LO  = (Q + 1) / 2;
    localparam int HI  = Q - LO;
    localparam int P_W = Q + DW;
    localparam int S_W = P_W - F;
    localparam int T_W = S_W + 1;
    localparam int Y_W = T_W + 2;
    localparam logic [Y_W-1:0] YMAX = {{(Y_W-DW+1){1'b0}}, {(DW-1){1'b1}}};
    localparam logic [Y_W-1:0] YMIN = {{(Y_W-DW+1){1'b1}}, {(DW-1){1'b0}}};

    // stage 1: operand magnitudes
    logic          v1_reg;
    logic [Q-1:0]  a1_reg;
    logic [DW-1:0] mq1_reg, m11_reg;
    logic [DW-1:0] mq1_next, m11_next;
    logic          nq1_reg, n11_reg;
    logic [DW-1:0] y1_1_reg, y2_1_reg;
    logic          act1_reg, zero1_reg;

    // stage 2: partial products
    logic            v2_reg;
    logic [LO+DW-1:0] plq2_reg, pl12_reg, plq2_next, pl12_next;
    logic [HI+DW-1:0] phq2_reg, ph12_reg, phq2_next, ph12_next;
    logic            nq2_reg, n12_reg;
    logic [DW-1:0]   y1_2_reg, y2_2_reg;
    logic            act2_reg, zero2_reg;

    // stage 3: full products
    logic           v3_reg;
    logic [P_W-1:0] pq3_reg, p13_reg, pq3_next, p13_next;
    logic           nq3_reg, n13_reg;
    logic [DW-1:0]  y1_3_reg, y2_3_reg;
    logic           act3_reg, zero3_reg;

    // stage 4: scaled and signed products
    logic           v4_reg;
    logic [T_W-1:0] sq_ext, s1_ext;
    logic [T_W-1:0] tq4_reg, t14_reg, tq4_next, t14_next;
    logic [DW-1:0]  y1_4_reg, y2_4_reg;
    logic           act4_reg, zero4_reg;

    // stage 5: line value and clamp limits
    logic           v5_reg;
    logic [Y_W-1:0] y5_reg, y5_next;
    logic [DW-1:0]  top5_reg, bot5_reg, top5_next, bot5_next;
    logic [DW-1:0]  y1_5_reg;
    logic           act5_reg, zero5_reg;

    // stage 6: clamp and saturate
    logic                  v6_reg;
    logic [DW-1:0]         res6_reg, res6_next;
    logic                  zero6_reg;
    logic                  sat6_reg, sat6_next;
    logic signed [Y_W-1:0] ys, top_ext, bot_ext;

    assign mq1_next = query_x[DW-1] ? (~query_x + 1'b1) : query_x;
    assign m11_next = first_x[DW-1] ? (~first_x + 1'b1) : first_x;

    assign plq2_next = a1_reg[LO-1:0] * mq1_reg;
    assign pl12_next = a1_reg[LO-1:0] * m11_reg;
    assign phq2_next = a1_reg[Q-1:LO] * mq1_reg;
    assign ph12_next = a1_reg[Q-1:LO] * m11_reg;

    assign pq3_next = {{HI{1'b0}}, plq2_reg} + {phq2_reg, {LO{1'b0}}};
    assign p13_next = {{HI{1'b0}}, pl12_reg} + {ph12_reg, {LO{1'b0}}};

    assign sq_ext   = {1'b0, pq3_reg[P_W-1:F]};
    assign s1_ext   = {1'b0, p13_reg[P_W-1:F]};
    assign tq4_next = nq3_reg ? (~sq_ext + 1'b1) : sq_ext;
    assign t14_next = n13_reg ? (~s1_ext + 1'b1) : s1_ext;

    assign y5_next = {{(Y_W-DW){y1_4_reg[DW-1]}}, y1_4_reg}
                   + {{(Y_W-T_W){tq4_reg[T_W-1]}}, tq4_reg}
                   - {{(Y_W-T_W){t14_reg[T_W-1]}}, t14_reg};
    assign top5_next = ($signed(y1_4_reg) > $signed(y2_4_reg)) ? y1_4_reg : y2_4_reg;
    assign bot5_next = ($signed(y1_4_reg) < $signed(y2_4_reg)) ? y1_4_reg : y2_4_reg;

    assign ys      = $signed(y5_reg);
    assign top_ext = $signed({{(Y_W-DW){top5_reg[DW-1]}}, top5_reg});
    assign bot_ext = $signed({{(Y_W-DW){bot5_reg[DW-1]}}, bot5_reg});

    always_comb
    begin
        res6_next = y5_reg[DW-1:0];
        sat6_next = 1'b0;
        priority if (zero5_reg)
        begin
            res6_next = y1_5_reg;
        end
        else if (act5_reg)
        begin
            priority if (ys > top_ext)
            begin
                res6_next = top5_reg;
            end
            else if (ys < bot_ext)
            begin
                res6_next = bot5_reg;
            end
            else
            begin
                res6_next = y5_reg[DW-1:0];
            end
        end
        else
        begin
            priority if (ys > $signed(YMAX))
            begin
                res6_next = YMAX[DW-1:0];
                sat6_next = 1'b1;
            end
            else if (ys < $signed(YMIN))
            begin
                res6_next = YMIN[DW-1:0];
                sat6_next = 1'b1;
            end
            else
            begin
                res6_next = y5_reg[DW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= vld_in;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a1_reg    <= quo;
            mq1_reg   <= mq1_next;
            m11_reg   <= m11_next;
            nq1_reg   <= qneg ^ query_x[DW-1];
            n11_reg   <= qneg ^ first_x[DW-1];
            y1_1_reg  <= first_y;
            y2_1_reg  <= second_y;
            act1_reg  <= action;
            zero1_reg <= zero;

            plq2_reg  <= plq2_next;
            pl12_reg  <= pl12_next;
            phq2_reg  <= phq2_next;
            ph12_reg  <= ph12_next;
            nq2_reg   <= nq1_reg;
            n12_reg   <= n11_reg;
            y1_2_reg  <= y1_1_reg;
            y2_2_reg  <= y2_1_reg;
            act2_reg  <= act1_reg;
            zero2_reg <= zero1_reg;

            pq3_reg   <= pq3_next;
            p13_reg   <= p13_next;
            nq3_reg   <= nq2_reg;
            n13_reg   <= n12_reg;
            y1_3_reg  <= y1_2_reg;
            y2_3_reg  <= y2_2_reg;
            act3_reg  <= act2_reg;
            zero3_reg <= zero2_reg;

            tq4_reg   <= tq4_next;
            t14_reg   <= t14_next;
            y1_4_reg  <= y1_3_reg;
            y2_4_reg  <= y2_3_reg;
            act4_reg  <= act3_reg;
            zero4_reg <= zero3_reg;

            y5_reg    <= y5_next;
            top5_reg  <= top5_next;
            bot5_reg  <= bot5_next;
            y1_5_reg  <= y1_4_reg;
            act5_reg  <= act4_reg;
            zero5_reg <= zero4_reg;

            res6_reg  <= res6_next;
            sat6_reg  <= sat6_next;
            zero6_reg <= zero5_reg;
        end
    end

    assign vld_out  = v6_reg;
    assign res_y    = res6_reg;
    assign res_zero = zero6_reg;
    assign res_sat  = sat6_reg;

endmodule

### design/fpli_skid.sv
module fpli_skid #(
    parameter int DW = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          pipe_vld,
    input  logic [DW-1:0] pipe_y,
    input  logic          pipe_zero,
    input  logic          pipe_sat,
    input  logic          result_stall,
    output logic          en,
    output logic          result_valid,
    output logic [DW-1:0] result_y,
    output logic          zero_span,
    output logic          saturated
);

    logic          out_vld_reg, out_vld_next;
    logic [DW-1:0] out_y_reg;
    logic          out_zero_reg, out_sat_reg;
    logic          skid_vld_reg, skid_vld_next;
    logic [DW-1:0] skid_y_reg;
    logic          skid_zero_reg, skid_sat_reg;
    logic          arrive;
    logic          take;
    logic          load_out_pipe;
    logic          load_out_skid;
    logic          load_skid;

    assign en     = !skid_vld_reg;
    assign arrive = pipe_vld && en;
    assign take   = out_vld_reg && !result_stall;

    assign load_out_pipe = arrive && (!out_vld_reg || take);
    assign load_skid     = arrive && out_vld_reg && !take;
    assign load_out_skid = take && skid_vld_reg;

    always_comb
    begin
        out_vld_next  = out_vld_reg;
        skid_vld_next = skid_vld_reg;
        priority if (load_out_pipe || load_out_skid)
        begin
            out_vld_next = 1'b1;
        end
        else if (take)
        begin
            out_vld_next = 1'b0;
        end
        else
        begin
            out_vld_next = out_vld_reg;
        end
        priority if (load_skid)
        begin
            skid_vld_next = 1'b1;
        end
        else if (load_out_skid)
        begin
            skid_vld_next = 1'b0;
        end
        else
        begin
            skid_vld_next = skid_vld_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg  <= out_vld_next;
            skid_vld_reg <= skid_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out_skid)
        begin
            out_y_reg    <= skid_y_reg;
            out_zero_reg <= skid_zero_reg;
            out_sat_reg  <= skid_sat_reg;
        end
        else if (load_out_pipe)
        begin
            out_y_reg    <= pipe_y;
            out_zero_reg <= pipe_zero;
            out_sat_reg  <= pipe_sat;
        end
        if (load_skid)
        begin
            skid_y_reg    <= pipe_y;
            skid_zero_reg <= pipe_zero;
            skid_sat_reg  <= pipe_sat;
        end
    end

    assign result_valid = out_vld_reg;
    assign result_y     = out_y_reg;
    assign zero_span    = out_zero_reg;
    assign saturated    = out_sat_reg;

endmodule

### design/fixed_point_line_interpolator_top.sv
// Two-point line evaluator: each request carries two known points, a query x and
// a mode bit, and yields one result y with zero-span and saturation flags. A new
// request is taken every cycle while request_stall is low. A request passes an
// operand register and the slope divider, which resolves one quotient bit per
// pipeline stage, followed by six stages of partial-product multiply, scaling,
// offset add and clamp/saturate and one output register. request_stall rises
// only after result_stall has held a result long enough to fill the output
// register and its skid entry.
module fixed_point_line_interpolator_top #(
    parameter int DATA_WIDTH = fpli_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = fpli_pkg::FRAC_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         request_valid,
    output logic                         request_stall,
    input  logic                         action,
    input  logic signed [DATA_WIDTH-1:0] first_x,
    input  logic signed [DATA_WIDTH-1:0] second_x,
    input  logic signed [DATA_WIDTH-1:0] first_y,
    input  logic signed [DATA_WIDTH-1:0] second_y,
    input  logic signed [DATA_WIDTH-1:0] query_x,
    output logic                         result_valid,
    input  logic                         result_stall,
    output logic signed [DATA_WIDTH-1:0] result_y,
    output logic                         zero_span,
    output logic                         saturated
);
    import fpli_pkg::*;

    localparam int DW     = DATA_WIDTH;
    localparam int Q      = DATA_WIDTH + FRAC_BITS;
    localparam int SIDE_W = SIDE_FIELDS * DW + SIDE_FLAGS;

    logic              en;
    logic              vld_s  [0:Q];
    logic [Q-1:0]      num_s  [0:Q];
    logic [SIDE_W-1:0] side_s [0:Q];
    logic [DW-1:0]     rem_s  [0:Q-1];
    logic [DW-1:0]     den_s  [0:Q-1];
    logic              ev_vld;
    logic [DW-1:0]     ev_y;
    logic              ev_zero;
    logic              ev_sat;
    logic [DW-1:0]     res_y;

    assign request_stall = !en;

    fpli_prep #(
        .DW (DW),
        .F  (FRAC_BITS)
    ) u_prep (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (en),
        .request_valid (request_valid),
        .action        (action),
        .first_x       (first_x),
        .second_x      (second_x),
        .first_y       (first_y),
        .second_y      (second_y),
        .query_x       (query_x),
        .vld           (vld_s[0]),
        .rem           (rem_s[0]),
        .num           (num_s[0]),
        .den           (den_s[0]),
        .side          (side_s[0])
    );

    for (genvar k = 0; k < Q; k++)
    begin : g_div
        if (k == Q - 1)
        begin : g_last
            fpli_div_stage #(
                .DW     (DW),
                .Q      (Q),
                .SIDE_W (SIDE_W)
            ) u_stage (
                .clk      (clk),
                .rst_n    (rst_n),
                .en       (en),
                .vld_in   (vld_s[k]),
                .rem_in   (rem_s[k]),
                .num_in   (num_s[k]),
                .den_in   (den_s[k]),
                .side_in  (side_s[k]),
                .vld_out  (vld_s[k+1]),
                .rem_out  (),
                .num_out  (num_s[k+1]),
                .den_out  (),
                .side_out (side_s[k+1])
            );
        end
        else
        begin : g_mid
            fpli_div_stage #(
                .DW     (DW),
                .Q      (Q),
                .SIDE_W (SIDE_W)
            ) u_stage (
                .clk      (clk),
                .rst_n    (rst_n),
                .en       (en),
                .vld_in   (vld_s[k]),
                .rem_in   (rem_s[k]),
                .num_in   (num_s[k]),
                .den_in   (den_s[k]),
                .side_in  (side_s[k]),
                .vld_out  (vld_s[k+1]),
                .rem_out  (rem_s[k+1]),
                .num_out  (num_s[k+1]),
                .den_out  (den_s[k+1]),
                .side_out (side_s[k+1])
            );
        end
    end

    fpli_eval #(
        .DW (DW),
        .F  (FRAC_BITS)
    ) u_eval (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .vld_in   (vld_s[Q]),
        .quo      (num_s[Q]),
        .qneg     (side_s[Q][SIDE_FIELDS*DW+FLAG_QNEG]),
        .action   (side_s[Q][SIDE_FIELDS*DW+FLAG_ACTION]),
        .zero     (side_s[Q][SIDE_FIELDS*DW+FLAG_ZERO]),
        .first_x  (side_s[Q][FLD_X1*DW +: DW]),
        .first_y  (side_s[Q][FLD_Y1*DW +: DW]),
        .second_y (side_s[Q][FLD_Y2*DW +: DW]),
        .query_x  (side_s[Q][FLD_XQ*DW +: DW]),
        .vld_out  (ev_vld),
        .res_y    (ev_y),
        .res_zero (ev_zero),
        .res_sat  (ev_sat)
    );

    fpli_skid #(
        .DW (DW)
    ) u_skid (
        .clk          (clk),
        .rst_n        (rst_n),
        .pipe_vld     (ev_vld),
        .pipe_y       (ev_y),
        .pipe_zero    (ev_zero),
        .pipe_sat     (ev_sat),
        .result_stall (result_stall),
        .en           (en),
        .result_valid (result_valid),
        .result_y     (res_y),
        .zero_span    (zero_span),
        .saturated    (saturated)
    );

    assign result_y = res_y;

endmodule

### design/fpli_checker.sv
module fpli_checker #(
    parameter int DATA_WIDTH = fpli_pkg::DATA_WIDTH_DEF
) (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  request_valid,
    input logic                  request_stall,
    input logic                  result_valid,
    input logic                  result_stall,
    input logic [DATA_WIDTH-1:0] result_y,
    input logic                  zero_span,
    input logic                  saturated
);

    // a held result keeps its value
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result_y)
            && $stable(zero_span) && $stable(saturated))
        else $error("result changed while stalled");

    // equal x coordinates never report saturation
    a_zero_sat: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && zero_span |-> !saturated)
        else $error("zero span with saturation flag");

    // request stall only with a result sitting in the output register
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        request_stall |-> result_valid)
        else $error("request stalled with empty output");

    // request stall starts only after a stalled result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(request_stall) |-> $past(result_valid && result_stall))
        else $error("request stall without result stall");

endmodule

bind fixed_point_line_interpolator_top fpli_checker #(
    .DATA_WIDTH (DATA_WIDTH)
) u_fpli_checker (.*);
